### src/segmented_message_reassembler_unit_macros.svh
// assertion macros for the segmented message reassembler checker
// no dependencies
`ifndef SEGMENTED_MESSAGE_REASSEMBLER_UNIT_MACROS_SVH
`define SEGMENTED_MESSAGE_REASSEMBLER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SMR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smr check failed");

// next-cycle implication, disabled during reset
`define SMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smr check failed");

`endif

### src/smr_pkg.sv
// types and constants for the segmented message reassembler
// no dependencies
package smr_pkg;

	localparam int MSG_BYTES = 4096;
	localparam int SEG_BYTES = 8;
	localparam int HDR_BYTES = 2;
	localparam int ADDR_W    = 12;
	localparam int LEN_W     = 13;
	localparam int SEQ_W     = 15;
	localparam int FLEN_W    = 4;
	localparam int PLEN_W    = 3;
	localparam int ST_W      = 3;

	typedef logic [7:0]        byte_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [SEQ_W-1:0]  seq_t;
	typedef logic [PLEN_W-1:0] plen_t;

	typedef enum logic [ST_W-1:0] {
		ST_APPENDED  = 3'd0,
		ST_COMPLETE  = 3'd1,
		ST_NO_HEADER = 3'd2,
		ST_SEQ_ERROR = 3'd3,
		ST_DISCARDED = 3'd4,
		ST_OVERSIZE  = 3'd5,
		ST_READ      = 3'd6
	} status_t;

	typedef enum logic {
		OP_DELIVER = 1'b0,
		OP_READ    = 1'b1
	} op_t;

endpackage

### src/smr_if.sv
// request and result channel interfaces for the segmented message reassembler
// depends on smr_pkg
interface smr_req_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [smr_pkg::FLEN_W-1:0] frame_len;
	logic [7:0]                 byte0;
	logic [7:0]                 byte1;
	logic [7:0]                 byte2;
	logic [7:0]                 byte3;
	logic [7:0]                 byte4;
	logic [7:0]                 byte5;
	logic [7:0]                 byte6;
	logic [7:0]                 byte7;
	logic [smr_pkg::ADDR_W-1:0] read_address;

	modport source (output valid, op, frame_len, byte0, byte1, byte2, byte3, byte4,
		byte5, byte6, byte7, read_address, input ready);
	modport sink (input valid, op, frame_len, byte0, byte1, byte2, byte3, byte4,
		byte5, byte6, byte7, read_address, output ready);
endinterface

interface smr_res_if;
	logic                      valid;
	logic                      ready;
	logic [smr_pkg::ST_W-1:0]  status;
	logic [smr_pkg::LEN_W-1:0] message_length;
	logic [smr_pkg::SEQ_W-1:0] expected_seq;
	logic [7:0]                read_byte;

	modport source (output valid, status, message_length, expected_seq, read_byte,
		input ready);
	modport sink (input valid, status, message_length, expected_seq, read_byte,
		output ready);
endinterface

### src/segmented_message_reassembler_unit.sv
// segmented message reassembler: header checks, fill and sequence state, byte store
// results: each accepted request passes through stage 1 and then the output register
// throughput: one request per cycle while results are taken; a frame with payload holds off new
// requests until its bytes, at most six, pass the single byte-wide write port of the message store
// reset: arst_n clears fill, sequence, discard and completed length; store is not cleared
// depends on smr_pkg, smr_if, smr_ram
module segmented_message_reassembler_unit (
	input  logic      clk,
	input  logic      arst_n,
	smr_req_if.sink   request,
	smr_res_if.source result
);
	import smr_pkg::*;

	len_t    fill_q, completed_q;
	seq_t    seq_q;
	logic    discard_q;

	logic    acc;
	logic [FLEN_W-1:0] flen_c;
	plen_t   plen_c;
	seq_t    hdr_seq;
	logic    hdr_last;
	logic [LEN_W:0] sum_c;

	status_t st_c;
	len_t    len_c, n_fill, n_completed;
	seq_t    n_seq;
	logic    n_discard;
	logic    wr_go_c, rd_go_c, rd_hit_c;

	logic    valid_s1, rd_hit_s1;
	status_t status_s1;
	len_t    len_s1;
	seq_t    exp_s1;
	logic    s1_move;

	logic    res_valid_q;
	status_t res_status_q;
	len_t    res_len_q;
	seq_t    res_exp_q;
	byte_t   res_byte_q;

	plen_t   wr_cnt_q;
	addr_t   wr_addr_q;
	byte_t   wr_buf_q [5];

	logic    ram_we;
	addr_t   ram_waddr;
	byte_t   ram_wdata, ram_rdata;

	assign acc      = request.valid && request.ready;
	assign flen_c   = (request.frame_len > FLEN_W'(SEG_BYTES)) ? FLEN_W'(SEG_BYTES)
		: request.frame_len;
	assign plen_c   = PLEN_W'(flen_c - FLEN_W'(HDR_BYTES));
	assign hdr_seq  = {request.byte0[6:0], request.byte1};
	assign hdr_last = request.byte0[7];
	assign sum_c    = {1'b0, fill_q} + (LEN_W+1)'(plen_c);

	always_comb begin
		st_c        = ST_APPENDED;
		len_c       = fill_q;
		n_fill      = fill_q;
		n_completed = completed_q;
		n_seq       = seq_q;
		n_discard   = discard_q;
		wr_go_c     = 1'b0;
		rd_go_c     = 1'b0;
		rd_hit_c    = 1'b0;
		if (request.op == OP_READ) begin
			st_c     = ST_READ;
			len_c    = completed_q;
			rd_go_c  = 1'b1;
			rd_hit_c = LEN_W'(request.read_address) < completed_q;
		end else if (flen_c < FLEN_W'(HDR_BYTES)) begin
			st_c = ST_NO_HEADER;
		end else if (discard_q && hdr_seq != '0) begin
			st_c = ST_DISCARDED;
			if (hdr_last) begin
				n_seq = '0;
			end
		end else begin
			if (discard_q) begin
				n_discard = 1'b0;
				n_seq     = '0;
			end
			if (hdr_seq != n_seq) begin
				st_c      = ST_SEQ_ERROR;
				n_discard = 1'b1;
				n_fill    = '0;
				n_seq     = '0;
				len_c     = '0;
			end else if (sum_c > (LEN_W+1)'(MSG_BYTES)) begin
				st_c   = ST_OVERSIZE;
				n_fill = '0;
				n_seq  = '0;
				len_c  = '0;
			end else begin
				wr_go_c = plen_c != '0;
				if (hdr_last) begin
					st_c        = ST_COMPLETE;
					n_completed = sum_c[LEN_W-1:0];
					n_fill      = '0;
					n_seq       = '0;
					len_c       = sum_c[LEN_W-1:0];
				end else begin
					st_c   = ST_APPENDED;
					n_fill = sum_c[LEN_W-1:0];
					n_seq  = n_seq + 1'b1;
					len_c  = sum_c[LEN_W-1:0];
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			completed_q <= '0;
			seq_q       <= '0;
			discard_q   <= 1'b0;
		end else if (acc) begin
			fill_q      <= n_fill;
			completed_q <= n_completed;
			seq_q       <= n_seq;
			discard_q   <= n_discard;
		end
	end

	// payload write engine, first byte written in the accept cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt_q <= '0;
		end else if (acc && wr_go_c) begin
			wr_cnt_q <= plen_c - 1'b1;
		end else if (wr_cnt_q != '0) begin
			wr_cnt_q <= wr_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && wr_go_c) begin
			wr_addr_q   <= fill_q[ADDR_W-1:0] + 1'b1;
			wr_buf_q[0] <= request.byte3;
			wr_buf_q[1] <= request.byte4;
			wr_buf_q[2] <= request.byte5;
			wr_buf_q[3] <= request.byte6;
			wr_buf_q[4] <= request.byte7;
		end else if (wr_cnt_q != '0) begin
			wr_addr_q <= wr_addr_q + 1'b1;
			for (int i = 0; i < 4; i++) begin
				wr_buf_q[i] <= wr_buf_q[i+1];
			end
		end
	end

	assign ram_we    = (acc && wr_go_c) || (wr_cnt_q != '0);
	assign ram_waddr = (wr_cnt_q != '0) ? wr_addr_q : fill_q[ADDR_W-1:0];
	assign ram_wdata = (wr_cnt_q != '0) ? wr_buf_q[0] : request.byte2;

	smr_ram #(
		.WIDTH (8),
		.DEPTH (MSG_BYTES)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (acc && rd_go_c),
		.rd_addr (request.read_address),
		.rd_data (ram_rdata)
	);

	assign s1_move       = valid_s1 && (!res_valid_q || result.ready);
	assign request.ready = (wr_cnt_q == '0) && (!valid_s1 || s1_move);

	// stage 1, waits for the store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= st_c;
			len_s1    <= len_c;
			exp_s1    <= n_seq;
			rd_hit_s1 <= rd_hit_c;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_move) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			res_status_q <= status_s1;
			res_len_q    <= len_s1;
			res_exp_q    <= exp_s1;
			res_byte_q   <= rd_hit_s1 ? ram_rdata : '0;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.status         = res_status_q;
	assign result.message_length = res_len_q;
	assign result.expected_seq   = res_exp_q;
	assign result.read_byte      = res_byte_q;

endmodule

### src/smr_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module smr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### src/smr_checker.sv
// port-level checks on the reassembler result channel, bound to the top level
// depends on smr_pkg and segmented_message_reassembler_unit_macros.svh
`include "segmented_message_reassembler_unit_macros.svh"

module smr_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic [smr_pkg::ST_W-1:0]  res_status,
	input logic [smr_pkg::LEN_W-1:0] res_length,
	input logic [smr_pkg::SEQ_W-1:0] res_seq,
	input logic [7:0]                res_byte
);
	import smr_pkg::*;

	`SMR_ASSERT_NEXT(a_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_length) && $stable(res_seq) && $stable(res_byte))
	`SMR_ASSERT_NOW(a_byte_only_on_read, clk, arst_n, res_valid && res_status != ST_READ, res_byte == '0)
	`SMR_ASSERT_NOW(a_seq_restart, clk, arst_n, res_valid && (res_status == ST_COMPLETE || res_status == ST_SEQ_ERROR || res_status == ST_OVERSIZE), res_seq == '0)
	`SMR_ASSERT_NOW(a_fill_cleared, clk, arst_n, res_valid && (res_status == ST_SEQ_ERROR || res_status == ST_OVERSIZE), res_length == '0)

endmodule

bind segmented_message_reassembler_unit smr_checker u_smr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_status (result.status),
	.res_length (result.message_length),
	.res_seq    (result.expected_seq),
	.res_byte   (result.read_byte)
);

### sim/smr_reassembly_checker.sv
// reassembly checker: watches the request and result channels, predicts each result
// from its own copy of fill, sequence, discard and completed length, and compares
// depends on smr_pkg and smr_if
`timescale 1ns / 1ps

module smr_reassembly_checker (
	input  logic clk,
	input  logic arst_n,
	smr_req_if   request,
	smr_res_if   result,
	output int   failures,
	output int   pending
);
	import smr_pkg::*;

	typedef struct packed {
		status_t status;
		len_t    length;
		seq_t    seq;
		byte_t   data;
	} outcome_t;

	byte_t    assembled [0:MSG_BYTES-1];
	int       fill_count;
	seq_t     seq_due;
	bit       dropping;
	int       done_length;
	outcome_t segment_outcomes [$];

	function automatic outcome_t reassemble_step(input op_t op, input logic [3:0] flen_raw,
		input logic [63:0] frame, input addr_t addr);
		outcome_t    o;
		int          flen;
		int          plen;
		int          i;
		logic [15:0] hdr;
		seq_t        seq;
		bit          finishes;
		o.status = ST_NO_HEADER;
		o.length = len_t'(fill_count);
		o.data   = '0;
		flen     = (flen_raw > SEG_BYTES) ? SEG_BYTES : int'(flen_raw);
		hdr      = {frame[7:0], frame[15:8]};
		seq      = hdr[14:0];
		finishes = hdr[15];
		plen     = flen - HDR_BYTES;
		if (op == OP_READ) begin
			o.status = ST_READ;
			o.length = len_t'(done_length);
			if (addr < done_length)
				o.data = assembled[addr];
		end else if (flen < HDR_BYTES) begin
			o.status = ST_NO_HEADER;
		end else if (dropping && seq != '0) begin
			if (finishes)
				seq_due = '0;
			o.status = ST_DISCARDED;
		end else begin
			if (dropping) begin
				dropping = 1'b0;
				seq_due  = '0;
			end
			if (seq != seq_due) begin
				dropping   = 1'b1;
				fill_count = 0;
				seq_due    = '0;
				o.status   = ST_SEQ_ERROR;
				o.length   = '0;
			end else if (fill_count + plen > MSG_BYTES) begin
				fill_count = 0;
				seq_due    = '0;
				o.status   = ST_OVERSIZE;
				o.length   = '0;
			end else begin
				for (i = 0; i < plen; i++)
					assembled[fill_count + i] = frame[8*(i + HDR_BYTES) +: 8];
				fill_count = fill_count + plen;
				seq_due    = seq_due + 1'b1;
				if (finishes) begin
					done_length = fill_count;
					fill_count  = 0;
					seq_due     = '0;
					o.status    = ST_COMPLETE;
					o.length    = len_t'(done_length);
				end else begin
					o.status = ST_APPENDED;
					o.length = len_t'(fill_count);
				end
			end
		end
		o.seq = seq_due;
		return o;
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		if (!arst_n) begin
			segment_outcomes.delete();
			fill_count  = 0;
			seq_due     = '0;
			dropping    = 1'b0;
			done_length = 0;
			pending    <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (segment_outcomes.size() == 0) begin
					$display("%0t: result with no request outstanding, expected none, got status %0d",
						$time, result.status);
					failures++;
				end else begin
					want = segment_outcomes.pop_front();
					compare_field("status", 32'(want.status), 32'(result.status));
					compare_field("message_length", 32'(want.length),
						32'(result.message_length));
					compare_field("expected_seq", 32'(want.seq), 32'(result.expected_seq));
					compare_field("read_byte", 32'(want.data), 32'(result.read_byte));
				end
			end
			if (request.valid && request.ready)
				segment_outcomes.push_back(reassemble_step(op_t'(request.op), request.frame_len,
					{request.byte7, request.byte6, request.byte5, request.byte4,
					 request.byte3, request.byte2, request.byte1, request.byte0},
					request.read_address));
			pending <= segment_outcomes.size();
		end
	end

endmodule

### sim/segmented_message_reassembler_unit_tb.sv
// top of the reassembler testbench: clock, reset, request stimulus and result stalls
// results are predicted and compared by smr_reassembly_checker beside the block
// depends on smr_pkg, smr_if, smr_reassembly_checker and the block itself
`timescale 1ns / 1ps

module segmented_message_reassembler_unit_tb;
	import smr_pkg::*;

	localparam int CYCLE_LIMIT   = 200_000;
	localparam int SETTLE_CYCLES = 16;
	localparam int MIXED_ITEMS   = 130;

	logic        clk;
	logic        arst_n;
	int          failures;
	int          outstanding;
	int          cycles = 0;
	int          burst_left;
	int          requests_sent;
	int          known_len;
	bit          clean;
	int          pattern_left = 0;
	logic [15:0] ready_pattern = 16'hFFFF;

	smr_req_if request();
	smr_res_if result();

	segmented_message_reassembler_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.result (result)
	);

	smr_reassembly_checker reassembly_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.result  (result),
		.failures(failures),
		.pending (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver stalls: a rotating pattern, changed now and then
	always @(posedge clk) begin
		if (pattern_left == 0) begin
			pattern_left  = $urandom_range(64, 512);
			ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF :
				16'($urandom_range(0, 65535) | 16'h1111);
		end
		pattern_left = pattern_left - 1;
		result.ready <= ready_pattern[cycles % 16];
	end

	task automatic present(input op_t op, input logic [3:0] flen, input logic [63:0] frame,
		input addr_t addr);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 10);
			if (gap > 0) begin
				request.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
		end
		request.valid        <= 1'b1;
		request.op           <= op;
		request.frame_len    <= flen;
		request.byte0        <= frame[7:0];
		request.byte1        <= frame[15:8];
		request.byte2        <= frame[23:16];
		request.byte3        <= frame[31:24];
		request.byte4        <= frame[39:32];
		request.byte5        <= frame[47:40];
		request.byte6        <= frame[55:48];
		request.byte7        <= frame[63:56];
		request.read_address <= addr;
		@(posedge clk);
		while (!request.ready) @(posedge clk);
		burst_left--;
		requests_sent++;
	endtask

	task automatic drain();
		request.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] frame_word(input seq_t seq, input bit finishes);
		logic [63:0] fb;
		fb        = {$urandom, $urandom};
		fb[7:0]   = {finishes, seq[14:8]};
		fb[15:8]  = seq[7:0];
		return fb;
	endfunction

	task automatic deliver(input int seq, input bit finishes, input int plen);
		logic [3:0] flen;
		flen = 4'(plen + HDR_BYTES);
		if (plen == SEG_BYTES - HDR_BYTES && $urandom_range(0, 7) == 0)
			flen = 4'($urandom_range(9, 15));
		present(OP_DELIVER, flen, frame_word(seq_t'(seq), finishes), addr_t'($urandom));
	endtask

	task automatic read_at(input int addr);
		present(OP_READ, 4'($urandom), {$urandom, $urandom}, addr_t'(addr));
	endtask

	function automatic int pick_address();
		int pick;
		pick = $urandom_range(0, 9);
		if (known_len == 0 || pick > 7)
			return $urandom_range(0, MSG_BYTES - 1);
		if (pick == 7 && known_len < MSG_BYTES)
			return known_len;
		return $urandom_range(0, known_len - 1);
	endfunction

	// reads and headerless frames leave the assembly state alone
	task automatic side_request();
		if ($urandom_range(0, 9) < 7)
			read_at(pick_address());
		else
			present(OP_DELIVER, 4'($urandom_range(0, 1)), {$urandom, $urandom},
				addr_t'($urandom));
	endtask

	// any nonzero sequence far above the live count lands in discard with nothing held
	task automatic resync();
		deliver($urandom_range(16384, 32767), 1'($urandom_range(0, 1)),
			$urandom_range(0, 6));
	endtask

	task automatic send_message(input int frames);
		int k;
		int plen;
		int total;
		if (!clean)
			resync();
		total = 0;
		for (k = 0; k < frames; k++) begin
			plen = $urandom_range(0, 6);
			while ($urandom_range(0, 4) == 0)
				side_request();
			deliver(k, k == frames - 1, plen);
			total = total + plen;
		end
		clean     = 1'b1;
		known_len = total;
	endtask

	task automatic send_broken();
		int frames;
		int bad;
		int k;
		int s;
		frames = $urandom_range(2, 8);
		bad    = $urandom_range(0, frames - 1);
		if (!clean)
			resync();
		for (k = 0; k < frames; k++) begin
			s = k;
			if (k == bad) begin
				case ($urandom_range(0, 2))
					0: s = k + $urandom_range(1, 3);
					1: s = (k > 0) ? k - 1 : 5;
					default: s = $urandom_range(0, 32767);
				endcase
			end else if (k > bad && $urandom_range(0, 3) == 0) begin
				s = 0;
			end
			if ($urandom_range(0, 5) == 0)
				side_request();
			deliver(s, k == frames - 1 || $urandom_range(0, 7) == 0, $urandom_range(0, 6));
		end
		clean = 1'b0;
	endtask

	// fills the store to the brim, then either closes it or runs over
	task automatic long_message(input bit close_it);
		int k;
		if (!clean)
			resync();
		for (k = 0; k < 682; k++) begin
			if ($urandom_range(0, 39) == 0)
				side_request();
			deliver(k, 1'b0, 6);
		end
		deliver(682, 1'b0, 4);
		if (close_it) begin
			deliver(683, 1'b1, 0);
			known_len = MSG_BYTES;
		end else begin
			deliver(683, 1'($urandom_range(0, 1)), $urandom_range(1, 6));
		end
		clean = 1'b1;
	endtask

	task automatic mixed_traffic(input int count);
		int stop_at;
		int pick;
		stop_at = requests_sent + count;
		while (requests_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_message(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) :
					$urandom_range(1, 8));
			end else if (pick < 70) begin
				send_broken();
			end else if (pick < 82) begin
				present(op_t'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
					{$urandom, $urandom}, addr_t'($urandom));
				clean = 1'b0;
			end else begin
				repeat ($urandom_range(1, 6)) side_request();
			end
		end
	endtask

	initial begin : stimulus
		arst_n               <= 1'b0;
		request.valid        <= 1'b0;
		request.op           <= OP_DELIVER;
		request.frame_len    <= '0;
		request.byte0        <= '0;
		request.byte1        <= '0;
		request.byte2        <= '0;
		request.byte3        <= '0;
		request.byte4        <= '0;
		request.byte5        <= '0;
		request.byte6        <= '0;
		request.byte7        <= '0;
		request.read_address <= '0;
		burst_left    = 0;
		requests_sent = 0;
		known_len     = 0;
		clean         = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing completed yet, headerless frames, clamped length
		read_at(0);
		read_at(MSG_BYTES - 1);
		present(OP_DELIVER, 4'd0, {$urandom, $urandom}, '0);
		present(OP_DELIVER, 4'd1, {$urandom, $urandom}, '1);
		deliver(0, 1'b0, 6);
		present(OP_DELIVER, 4'd15, frame_word(1, 1'b0), '0);
		read_at(0);
		deliver(2, 1'b1, 0);
		read_at(0);
		read_at(11);
		read_at(12);
		// sequence error, discard, restart on sequence zero
		deliver(5, 1'b0, 3);
		deliver(3, 1'b0, 2);
		deliver(7, 1'b1, 6);
		deliver(0, 1'b0, 3);
		read_at(1);
		read_at(10);
		deliver(1, 1'b1, 2);
		read_at(4);
		deliver(32767, 1'b1, 6);
		deliver(0, 1'b1, 0);
		known_len = 0;

		long_message(1'b1);
		repeat (8) read_at(pick_address());
		drain();
		mixed_traffic(MIXED_ITEMS);
		long_message(1'b0);

		mixed_traffic(MIXED_ITEMS);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
